// ===== rtl/core/rps_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rps_pkg
// shared constants and controller/datapath interface types of the shuffler
// ----------------------------------------------------------------------------
package rps_pkg;

  localparam int MAX_ELEMENTS_DEF = 256;
  localparam int CFG_W            = 9;
  localparam int WORD_W           = 31;
  localparam int OUT_W            = 8;
  localparam int CNT_W            = $clog2(WORD_W);
  localparam logic [CFG_W-1:0] LEN_RESET = 9'd256;

  // commands from the controller, one step of work each
  typedef struct packed {
    logic start;     // latch word, length and position, prime the divider
    logic div_step;  // one restoring-division bit
    logic rd_i;      // issue table read at position
    logic rd_j;      // issue table read at partner
    logic wr_j;      // write partner slot
    logic wr_i;      // write position slot
    logic finish;    // load result register, advance the walk
  } cmd_t;

  typedef struct packed {
    logic div_done;  // last division bit this cycle
    logic out_free;  // result register can take a new value
  } status_t;

endpackage : rps_pkg
`default_nettype wire

// ===== rtl/core/rps_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rps_ctrl
// step sequencer: accept, divide, read both slots, write both slots, emit
// ----------------------------------------------------------------------------
module rps_ctrl
  import rps_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire status_t status,
  output cmd_t         cmd
);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_DIV  = 7'b0000010,
    ST_RDI  = 7'b0000100,
    ST_RDJ  = 7'b0001000,
    ST_WRJ  = 7'b0010000,
    ST_WRI  = 7'b0100000,
    ST_DONE = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_done) state_nxt = ST_RDI;
      end
      ST_RDI: begin
        cmd.rd_i  = 1'b1;
        state_nxt = ST_RDJ;
      end
      ST_RDJ: begin
        cmd.rd_j  = 1'b1;
        state_nxt = ST_WRJ;
      end
      ST_WRJ: begin
        cmd.wr_j  = 1'b1;
        state_nxt = ST_WRI;
      end
      ST_WRI: begin
        cmd.wr_i  = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_ready = (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule : rps_ctrl
`default_nettype wire

// ===== rtl/core/rps_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rps_datapath
// length register, bit-serial modulo, permutation table, marks, result register
// ----------------------------------------------------------------------------
module rps_datapath
  import rps_pkg::*;
#(
  parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cmd_t              cmd,
  output status_t                status,
  input  wire logic              cfg_we,
  input  wire logic [CFG_W-1:0]  cfg_wdata,
  input  wire logic [WORD_W-1:0] in_random_word,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [OUT_W-1:0]       out_position,
  output logic [OUT_W-1:0]       out_element,
  output logic                   out_last
);

  localparam int IW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int LW = $clog2(MAX_ELEMENTS + 1);
  localparam int CW = (LW > CFG_W) ? LW : CFG_W;
  localparam logic [CW-1:0] MAX_C = CW'(MAX_ELEMENTS);

  logic [CFG_W-1:0]  cfg_len_r;
  logic [LW-1:0]     len_r;
  logic [IW-1:0]     step_r;
  logic [IW-1:0]     i_r;
  logic [IW-1:0]     j_r;
  logic [WORD_W-1:0] word_r;
  logic [LW-1:0]     rem_r;
  logic [LW-1:0]     remaining_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [IW-1:0]     val_i_r;
  logic [IW-1:0]     val_j_r;
  logic [MAX_ELEMENTS-1:0] marks_r;
  logic [IW-1:0]     mem [MAX_ELEMENTS];
  logic [IW-1:0]     ram_q_r;
  logic [IW-1:0]     addr_q_r;
  logic              mark_q_r;
  logic              out_valid_r;
  logic [OUT_W-1:0]  out_position_r;
  logic [OUT_W-1:0]  out_element_r;
  logic              out_last_r;

  logic [CW-1:0]     cfg_ext;
  logic [LW-1:0]     len_eff;
  logic              wrap;
  logic [IW-1:0]     i_start;
  logic [LW:0]       trial;
  logic [LW:0]       trial_sub;
  logic [IW-1:0]     j_c;
  logic [IW-1:0]     raddr;
  logic [IW-1:0]     slot_val;
  logic              is_last;

  // effective length: zero reads as one, saturate at table depth
  always_comb begin
    cfg_ext = CW'(cfg_len_r);
    if (cfg_ext == '0) begin
      len_eff = LW'(1);
    end else if (cfg_ext > MAX_C) begin
      len_eff = LW'(MAX_C);
    end else begin
      len_eff = LW'(cfg_ext);
    end
  end

  assign wrap      = (LW'(step_r) >= len_eff);
  assign i_start   = wrap ? '0 : step_r;
  assign trial     = {rem_r, word_r[WORD_W-1]};
  assign trial_sub = trial - {1'b0, remaining_r};
  assign j_c       = i_r + rem_r[IW-1:0];
  assign raddr     = cmd.rd_j ? j_r : i_r;
  assign slot_val  = mark_q_r ? ram_q_r : addr_q_r;
  assign is_last   = (LW'(i_r) == (len_r - LW'(1)));

  assign status = '{div_done: (cnt_r == CNT_W'(WORD_W - 1)),
                    out_free: (!out_valid_r || out_ready)};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_len_r <= LEN_RESET;
    end else if (cfg_we) begin
      cfg_len_r <= cfg_wdata;
    end
  end

  // control state: walk position, marks, result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= '0;
      marks_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.start && wrap) marks_r <= '0;
      if (cmd.wr_j) marks_r[j_r] <= 1'b1;
      if (cmd.wr_i) marks_r[i_r] <= 1'b1;
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
        if (is_last) begin
          step_r  <= '0;
          marks_r <= '0;
        end else begin
          step_r <= i_r + IW'(1);
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      len_r       <= len_eff;
      i_r         <= i_start;
      remaining_r <= len_eff - LW'(i_start);
      word_r      <= in_random_word;
      rem_r       <= '0;
      cnt_r       <= '0;
    end
    if (cmd.div_step) begin
      rem_r  <= trial_sub[LW] ? trial[LW-1:0] : trial_sub[LW-1:0];
      word_r <= {word_r[WORD_W-2:0], 1'b0};
      cnt_r  <= cnt_r + CNT_W'(1);
    end
    if (cmd.rd_i) j_r <= j_c;
    if (cmd.rd_j) val_i_r <= slot_val;
    if (cmd.wr_j) val_j_r <= slot_val;
    if (cmd.finish) begin
      out_position_r <= OUT_W'(i_r);
      out_element_r  <= OUT_W'(val_j_r);
      out_last_r     <= is_last;
    end
  end

  // permutation table, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.wr_j) begin
      mem[j_r] <= val_i_r;
    end else if (cmd.wr_i) begin
      mem[i_r] <= val_j_r;
    end
    ram_q_r  <= mem[raddr];
    mark_q_r <= marks_r[raddr];
    addr_q_r <= raddr;
  end

  assign out_valid    = out_valid_r;
  assign out_position = out_position_r;
  assign out_element  = out_element_r;
  assign out_last     = out_last_r;

  a_rem_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_i |-> (rem_r < remaining_r))
    else $error("partner offset not below remaining count");

  a_partner_marked: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_i |-> marks_r[j_r])
    else $error("partner slot not marked after its write");

  a_walk_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.finish && is_last) |=> (step_r == '0) && (marks_r == '0))
    else $error("walk not cleared after final slot");

endmodule : rps_datapath
`default_nettype wire

// ===== rtl/core/random_permutation_shuffler.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// random_permutation_shuffler
// fisher-yates shuffle: one random word per transfer, one swap step, one slot out
// ----------------------------------------------------------------------------
// an input word is taken only in the idle state, so a new item waits until the
//   previous result is loaded into the output register; the bit-serial modulo
//   unit works one remainder bit per cycle over the 31-bit word, and the
//   table takes two reads and two writes in turn
// a finished result waits in the output register while the next item runs
// reset: synchronous, active low; clears the walk position, the written marks,
//   the sequencer and sets the length register to 256; table is not cleared
// ----------------------------------------------------------------------------
module random_permutation_shuffler
  import rps_pkg::*;
#(
  parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // configuration: permutation length
  input  wire logic              cfg_we,
  input  wire logic [CFG_W-1:0]  cfg_wdata,
  // input channel: one random word per step
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [WORD_W-1:0] in_random_word,
  // result channel: slot made final by the step
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [OUT_W-1:0]       out_position,
  output logic [OUT_W-1:0]       out_element,
  output logic                   out_last
);

  cmd_t    cmd;
  status_t status;

  // sequencer: idle -> divide -> read i -> read j -> write j -> write i -> emit
  rps_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath holds the length register, modulo unit, table, marks and result
  rps_datapath #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_random_word (in_random_word),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_position   (out_position),
    .out_element    (out_element),
    .out_last       (out_last)
  );

endmodule : random_permutation_shuffler
`default_nettype wire

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the fisher-yates shuffler: random words go in, one
// final slot comes out per word and is checked against a shuffle model kept
// in the bench, under several permutation lengths and random flow control
// ----------------------------------------------------------------------------
module tb_top
  import rps_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 700;
  localparam int DRAIN_CYCLES = 50;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int HOLD_OFF_AT = 60;     // result count that triggers the long stall
  localparam int DIR_ROWS = 23;

  // one slot made final by a swap step
  typedef struct packed {
    logic [OUT_W-1:0] position;
    logic [OUT_W-1:0] element;
    logic             last;
  } slot_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  // directed stimulus row: either a length write or one word, optionally with
  // a hand-written expected slot
  typedef struct packed {
    row_kind_e         kind;
    logic [CFG_W-1:0]  len;
    logic [WORD_W-1:0] word;
    logic              typed;
    slot_t             slot;
  } row_t;

  localparam logic [WORD_W-1:0] W_ZERO = '0;
  localparam logic [WORD_W-1:0] W_ONES = '1;
  localparam logic [WORD_W-1:0] W_ALT0 = 31'h2AAAAAAA;
  localparam logic [WORD_W-1:0] W_ALT1 = 31'h55555555;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [CFG_W-1:0]  cfg_wdata;
  logic              in_valid;
  logic              in_ready;
  logic [WORD_W-1:0] in_random_word;
  logic              out_valid;
  logic              out_ready;
  logic [OUT_W-1:0]  out_position;
  logic [OUT_W-1:0]  out_element;
  logic              out_last;

  random_permutation_shuffler i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_random_word (in_random_word),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_position   (out_position),
    .out_element    (out_element),
    .out_last       (out_last)
  );

  // 10 ns clock, low first so the first rising edge comes at 5 ns
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // --------------------------------------------------------------------------
  // shuffle model: table, written marks, walk position and length register
  // --------------------------------------------------------------------------
  logic [OUT_W-1:0]            perm_tbl [0:MAX_ELEMENTS_DEF-1];
  bit [MAX_ELEMENTS_DEF-1:0]   placed;
  int unsigned                 walk_pos;
  logic [CFG_W-1:0]            len_reg;

  slot_t pending_slots [$];    // slots still owed by the block, oldest first
  int    errors;
  int    slots_seen;
  int    cycles;
  bit    no_gaps;              // both sides run without idling while set

  // one swap step of the walk; updates the model and returns the final slot
  function automatic slot_t shuffle_step(input logic [WORD_W-1:0] word);
    int unsigned len, j, vi, vj, w32;
    slot_t r;
    w32 = 32'(word);
    // zero acts as one, anything above the table size saturates
    if (len_reg == 0) len = 1;
    else if (len_reg > MAX_ELEMENTS_DEF) len = MAX_ELEMENTS_DEF;
    else len = 32'(len_reg);
    // length shrunk under the walk: restart at slot zero
    if (walk_pos >= len) begin
      placed = '0;
      walk_pos = 0;
    end
    j = walk_pos + w32 % (len - walk_pos);
    // untouched slots still hold their own index
    vi = placed[walk_pos] ? 32'(perm_tbl[walk_pos]) : walk_pos;
    vj = placed[j] ? 32'(perm_tbl[j]) : j;
    perm_tbl[j] = vi[7:0];
    placed[j] = 1'b1;
    perm_tbl[walk_pos] = vj[7:0];
    placed[walk_pos] = 1'b1;
    r.position = walk_pos[7:0];
    r.element = vj[7:0];
    r.last = (walk_pos == len - 1);
    if (r.last) begin
      placed = '0;
      walk_pos = 0;
    end else begin
      walk_pos = walk_pos + 1;
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // input side
  // --------------------------------------------------------------------------
  // offer one word and wait for its transfer; valid is only lowered when a gap
  // is drawn, so back-to-back words keep valid high
  task automatic send_word(input logic [WORD_W-1:0] word, input bit typed,
                           input slot_t slot);
    int gap;
    slot_t predicted;
    gap = no_gaps ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_random_word <= word;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // transfer at this edge; model always advances, typed rows override
    predicted = shuffle_step(word);
    pending_slots.push_back(typed ? slot : predicted);
  endtask

  // new length only once the block has handed over every owed slot
  task automatic write_length(input logic [CFG_W-1:0] len);
    in_valid <= 1'b0;
    while (pending_slots.size() != 0) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= len;
    @(posedge clk);
    len_reg = len;
    cfg_we <= 1'b0;
  endtask

  // mostly uniform words, with the extremes and small values mixed in
  function automatic logic [WORD_W-1:0] draw_word();
    case ($urandom_range(0, 9))
      0: return W_ZERO;
      1: return W_ONES;
      2: return WORD_W'($urandom_range(0, 600));
      default: return WORD_W'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] draw_length();
    case ($urandom_range(0, 7))
      0: return 9'd0;
      1: return 9'd1;
      2: return 9'd2;
      3: return 9'd256;
      4: return CFG_W'($urandom_range(257, 511));
      default: return CFG_W'($urandom_range(3, 40));
    endcase
  endfunction

  // directed rows: defaults after reset, length edges, shrink under the walk
  row_t dir_rows [0:DIR_ROWS-1];

  initial begin
    // after reset the length is 256 and word zero swaps slot 0 with itself
    dir_rows[0]  = '{ROW_ITEM, 9'd0,   W_ZERO, 1'b1, '{8'd0, 8'd0, 1'b0}};
    dir_rows[1]  = '{ROW_ITEM, 9'd0,   W_ONES, 1'b0, '0};
    dir_rows[2]  = '{ROW_ITEM, 9'd0,   W_ALT0, 1'b0, '0};
    // shrink to 2 with the walk at slot 3: walk restarts
    dir_rows[3]  = '{ROW_CFG,  9'd2,   W_ZERO, 1'b0, '0};
    dir_rows[4]  = '{ROW_ITEM, 9'd0,   W_ZERO, 1'b1, '{8'd0, 8'd0, 1'b0}};
    dir_rows[5]  = '{ROW_ITEM, 9'd0,   W_ZERO, 1'b1, '{8'd1, 8'd1, 1'b1}};
    dir_rows[6]  = '{ROW_ITEM, 9'd0,   W_ONES, 1'b1, '{8'd0, 8'd1, 1'b0}};
    dir_rows[7]  = '{ROW_ITEM, 9'd0,   W_ONES, 1'b1, '{8'd1, 8'd0, 1'b1}};
    // single-element permutation
    dir_rows[8]  = '{ROW_CFG,  9'd1,   W_ZERO, 1'b0, '0};
    dir_rows[9]  = '{ROW_ITEM, 9'd0,   W_ONES, 1'b1, '{8'd0, 8'd0, 1'b1}};
    dir_rows[10] = '{ROW_ITEM, 9'd0,   W_ALT0, 1'b1, '{8'd0, 8'd0, 1'b1}};
    // zero length behaves as one
    dir_rows[11] = '{ROW_CFG,  9'd0,   W_ZERO, 1'b0, '0};
    dir_rows[12] = '{ROW_ITEM, 9'd0,   W_ALT1, 1'b1, '{8'd0, 8'd0, 1'b1}};
    dir_rows[13] = '{ROW_ITEM, 9'd0,   W_ZERO, 1'b1, '{8'd0, 8'd0, 1'b1}};
    // register maximum saturates to the table size
    dir_rows[14] = '{ROW_CFG,  9'd511, W_ZERO, 1'b0, '0};
    dir_rows[15] = '{ROW_ITEM, 9'd0,   W_ONES, 1'b0, '0};
    dir_rows[16] = '{ROW_ITEM, 9'd0,   31'h12345678, 1'b0, '0};
    // just past the table size, walk carries on
    dir_rows[17] = '{ROW_CFG,  9'd257, W_ZERO, 1'b0, '0};
    dir_rows[18] = '{ROW_ITEM, 9'd0,   W_ALT1, 1'b0, '0};
    // shrink to 3 with the walk exactly at 3, then a whole walk of 3
    dir_rows[19] = '{ROW_CFG,  9'd3,   W_ZERO, 1'b0, '0};
    dir_rows[20] = '{ROW_ITEM, 9'd0,   W_ONES, 1'b0, '0};
    dir_rows[21] = '{ROW_ITEM, 9'd0,   W_ALT0, 1'b0, '0};
    dir_rows[22] = '{ROW_ITEM, 9'd0,   W_ONES, 1'b0, '0};
  end

  // --------------------------------------------------------------------------
  // stimulus: reset, directed table, then random length phases
  // --------------------------------------------------------------------------
  initial begin
    int sent, count, len_eff;
    logic [CFG_W-1:0] len;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    in_valid <= 1'b0;
    in_random_word <= '0;
    len_reg = LEN_RESET;
    placed = '0;
    walk_pos = 0;
    no_gaps = 1'b0;
    errors = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < DIR_ROWS; r++) begin
      if (dir_rows[r].kind == ROW_CFG) write_length(dir_rows[r].len);
      else send_word(dir_rows[r].word, dir_rows[r].typed, dir_rows[r].slot);
    end

    // random phases: each writes a length, then mostly whole walks (one or
    // two) and sometimes a partial walk so the next length lands mid-walk
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      len = draw_length();
      write_length(len);
      no_gaps = ($urandom_range(0, 3) == 0);
      if (len == 0) len_eff = 1;
      else if (len > MAX_ELEMENTS_DEF) len_eff = MAX_ELEMENTS_DEF;
      else len_eff = int'(len);
      if ($urandom_range(0, 3) == 0) count = $urandom_range(1, len_eff);
      else count = len_eff * $urandom_range(1, 2);
      // keep the total close to the planned item count
      if (count > RANDOM_ITEMS - sent) count = RANDOM_ITEMS - sent;
      for (int k = 0; k < count; k++) begin
        send_word(draw_word(), 1'b0, '0);
      end
      sent += count;
    end
    in_valid <= 1'b0;
    no_gaps = 1'b0;

    // drain: everything owed, then a latency's worth of quiet for strays
    while (pending_slots.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // result side: random stalls, one long hold-off to back up the block
  // --------------------------------------------------------------------------
  initial begin
    int stall;
    bit held;
    slot_t want;
    out_ready <= 1'b0;
    held = 1'b0;
    slots_seen = 0;
    @(posedge clk);
    forever begin
      if (!held && slots_seen == HOLD_OFF_AT) begin
        // sender keeps offering meanwhile, so in_ready must drop
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      stall = no_gaps ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      // transfer at this edge
      slots_seen++;
      if (pending_slots.size() == 0) begin
        $display("%0t: slot with nothing owed: position %0d element %0d last %0d",
                 $realtime, out_position, out_element, out_last);
        errors++;
      end else begin
        want = pending_slots.pop_front();
        if (out_position !== want.position) begin
          $display("%0t: position expected %0d actual %0d",
                   $realtime, want.position, out_position);
          errors++;
        end
        if (out_element !== want.element) begin
          $display("%0t: element at %0d expected %0d actual %0d",
                   $realtime, want.position, want.element, out_element);
          errors++;
        end
        if (out_last !== want.last) begin
          $display("%0t: last at %0d expected %0d actual %0d",
                   $realtime, want.position, want.last, out_last);
          errors++;
        end
      end
    end
  end

  // watchdog
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d slots still owed", $realtime,
               pending_slots.size());
      $display("TEST FAILED");
      $finish;
    end
  end

endmodule : tb_top
